@@ design/pdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pdfs_pkg
// Shared types and constants of the packet descriptor queue with statistics.
// ----------------------------------------------------------------------------
package pdfs_pkg;

	localparam int unsigned OP_W        = 3;
	localparam int unsigned LEN_W       = 16;
	localparam int unsigned HANDLE_W    = 16;
	localparam int unsigned CLASS_W     = 2;
	localparam int unsigned QCOUNT_W    = 7;
	localparam int unsigned CNT_W       = 32;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 7;

	localparam logic [QCOUNT_W-1:0] MAX_PACKETS_RST = 7'd64;
	localparam logic [CLASS_W-1:0]  QUEUE_CLASS_RST = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH       = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP        = 3'd2,
		OP_READ_STATS = 3'd3,
		OP_CLEAR_NEW  = 3'd4,
		OP_FLUSH      = 3'd5
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MAX_PACKETS = 1'b0,
		REG_QUEUE_CLASS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic                item_kind;
		logic [LEN_W-1:0]    total_length;
		logic [LEN_W-1:0]    data_length;
		logic [HANDLE_W-1:0] handle;
		logic [CLASS_W-1:0]  class_to_clear;
	} item_t;

	typedef struct packed {
		logic                accepted;
		logic [HANDLE_W-1:0] out_handle;
		logic [QCOUNT_W-1:0] queued_packets;
		logic [CNT_W-1:0]    queued_bytes;
		logic [CNT_W-1:0]    in_packets;
		logic [CNT_W-1:0]    out_packets;
		logic [CNT_W-1:0]    in_bytes;
		logic [CNT_W-1:0]    out_bytes;
		logic [CNT_W-1:0]    new_packets;
		logic [CNT_W-1:0]    new_bytes;
	} result_t;

endpackage

@@ design/pdfs_entry_ram.sv @@
// ----------------------------------------------------------------------------
// pdfs_entry_ram
// Descriptor store: one write port, one registered read port, with a bypass
// of a same-cycle write to the read address.
// ----------------------------------------------------------------------------
module pdfs_entry_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic [WIDTH-1:0] byp_data_q;
	logic             byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q       <= mem[raddr];
		byp_data_q <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= we && (waddr == raddr);
		end
	end

	assign rdata = byp_q ? byp_data_q : rd_q;

endmodule

@@ design/pdfs_queue_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdfs_queue_ctrl
// Ring pointers, occupancy, traffic counters and the cached head entry;
// computes the result of one operation and the store access for it.
// ----------------------------------------------------------------------------
module pdfs_queue_ctrl #(
	parameter int unsigned DEPTH       = 64,
	parameter int unsigned HANDLE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  pdfs_pkg::item_t                  item,
	input  logic [pdfs_pkg::QCOUNT_W-1:0]    max_packets,
	input  logic [pdfs_pkg::CLASS_W-1:0]     queue_class,
	input  logic [pdfs_pkg::LEN_W+((HANDLE_BITS < pdfs_pkg::HANDLE_W) ?
		HANDLE_BITS : pdfs_pkg::HANDLE_W)-1:0] ram_rdata,
	output logic                             ram_we,
	output logic [$clog2(DEPTH)-1:0]         ram_waddr,
	output logic [pdfs_pkg::LEN_W+((HANDLE_BITS < pdfs_pkg::HANDLE_W) ?
		HANDLE_BITS : pdfs_pkg::HANDLE_W)-1:0] ram_wdata,
	output logic [$clog2(DEPTH)-1:0]         ram_raddr,
	output pdfs_pkg::result_t                result
);

	localparam int unsigned AW  = $clog2(DEPTH);
	localparam int unsigned AW1 = AW + 1;
	localparam int unsigned CW  = $clog2(DEPTH + 1);
	localparam int unsigned LW  = (CW > pdfs_pkg::QCOUNT_W) ? CW : pdfs_pkg::QCOUNT_W;
	localparam int unsigned SHB = (HANDLE_BITS < pdfs_pkg::HANDLE_W) ?
		HANDLE_BITS : pdfs_pkg::HANDLE_W;
	localparam int unsigned EW  = SHB + pdfs_pkg::LEN_W;
	localparam int unsigned CNW = pdfs_pkg::CNT_W;

	logic [AW-1:0]  head_q, head_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CNW-1:0] level_q, level_d;
	logic [CNW-1:0] in_pkt_q, in_pkt_d;
	logic [CNW-1:0] out_pkt_q, out_pkt_d;
	logic [CNW-1:0] in_bytes_q, in_bytes_d;
	logic [CNW-1:0] out_bytes_q, out_bytes_d;
	logic [CNW-1:0] new_pkt_q, new_pkt_d;
	logic [CNW-1:0] new_bytes_q, new_bytes_d;
	logic [EW-1:0]  head_entry_q, head_entry_d;

	logic [LW-1:0]           limit;
	logic                    room;
	logic [AW1-1:0]          tail_sum;
	logic [AW-1:0]           tail;
	logic [AW-1:0]           head_dec;
	logic [pdfs_pkg::LEN_W-1:0] push_len;
	logic [pdfs_pkg::LEN_W-1:0] head_len;
	logic [CNW-1:0]          push_len_w;
	logic [CNW-1:0]          front_len_w;
	logic [CNW-1:0]          head_len_w;
	logic                    acc;
	logic [pdfs_pkg::HANDLE_W-1:0] oh;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign limit      = (LW'(max_packets) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(max_packets);
	assign room       = LW'(count_q) < limit;
	assign tail_sum   = AW1'(head_q) + AW1'(count_q);
	assign tail       = (tail_sum >= AW1'(DEPTH)) ? AW'(tail_sum - AW1'(DEPTH)) : AW'(tail_sum);
	assign head_dec   = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign push_len   = item.item_kind ? item.total_length : item.data_length;
	assign head_len   = head_entry_q[pdfs_pkg::LEN_W-1:0];
	assign push_len_w = CNW'(push_len);
	assign front_len_w = CNW'(item.total_length);
	assign head_len_w = CNW'(head_len);

	always_comb begin
		head_d       = head_q;
		count_d      = count_q;
		level_d      = level_q;
		in_pkt_d     = in_pkt_q;
		out_pkt_d    = out_pkt_q;
		in_bytes_d   = in_bytes_q;
		out_bytes_d  = out_bytes_q;
		new_pkt_d    = new_pkt_q;
		new_bytes_d  = new_bytes_q;
		head_entry_d = head_entry_q;
		ram_we       = 1'b0;
		ram_waddr    = tail;
		ram_wdata    = {item.handle[SHB-1:0], push_len};
		acc          = 1'b0;
		oh           = '0;
		if (fire) begin
			unique case (item.operation)
				pdfs_pkg::OP_PUSH: begin
					if (room) begin
						ram_we      = 1'b1;
						count_d     = count_q + 1'b1;
						level_d     = level_q + push_len_w;
						in_pkt_d    = in_pkt_q + 1'b1;
						in_bytes_d  = in_bytes_q + push_len_w;
						new_pkt_d   = new_pkt_q + 1'b1;
						new_bytes_d = new_bytes_q + push_len_w;
						acc         = 1'b1;
						if (count_q == '0) begin
							head_entry_d = ram_wdata;
						end
					end
				end
				pdfs_pkg::OP_PUSH_FRONT: begin
					ram_waddr = head_dec;
					ram_wdata = {item.handle[SHB-1:0], item.total_length};
					if (room) begin
						ram_we       = 1'b1;
						head_d       = head_dec;
						count_d      = count_q + 1'b1;
						level_d      = level_q + front_len_w;
						out_bytes_d  = out_bytes_q - front_len_w;
						head_entry_d = ram_wdata;
						acc          = 1'b1;
					end
				end
				pdfs_pkg::OP_POP: begin
					if (count_q != '0) begin
						oh           = pdfs_pkg::HANDLE_W'(head_entry_q[EW-1:pdfs_pkg::LEN_W]);
						head_d       = ptr_inc(head_q);
						count_d      = count_q - 1'b1;
						level_d      = level_q - head_len_w;
						out_pkt_d    = out_pkt_q + 1'b1;
						out_bytes_d  = out_bytes_q + head_len_w;
						head_entry_d = ram_rdata;
						acc          = 1'b1;
					end
				end
				pdfs_pkg::OP_READ_STATS: begin
					in_pkt_d    = '0;
					out_pkt_d   = '0;
					in_bytes_d  = '0;
					out_bytes_d = '0;
				end
				pdfs_pkg::OP_CLEAR_NEW: begin
					if (item.class_to_clear == queue_class) begin
						new_pkt_d = '0;
					end
				end
				pdfs_pkg::OP_FLUSH: begin
					head_d      = '0;
					count_d     = '0;
					level_d     = '0;
					in_pkt_d    = '0;
					out_pkt_d   = '0;
					in_bytes_d  = '0;
					out_bytes_d = '0;
					new_pkt_d   = '0;
					new_bytes_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign ram_raddr = ptr_inc(head_d);

	always_comb begin
		result.accepted       = acc;
		result.out_handle     = oh;
		result.queued_packets = pdfs_pkg::QCOUNT_W'(LW'(count_d));
		result.queued_bytes   = level_d;
		result.new_packets    = new_pkt_d;
		result.new_bytes      = new_bytes_d;
		if (item.operation == pdfs_pkg::OP_READ_STATS) begin
			result.in_packets  = in_pkt_q;
			result.out_packets = out_pkt_q;
			result.in_bytes    = in_bytes_q;
			result.out_bytes   = out_bytes_q;
		end else begin
			result.in_packets  = in_pkt_d;
			result.out_packets = out_pkt_d;
			result.in_bytes    = in_bytes_d;
			result.out_bytes   = out_bytes_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			level_q     <= '0;
			in_pkt_q    <= '0;
			out_pkt_q   <= '0;
			in_bytes_q  <= '0;
			out_bytes_q <= '0;
			new_pkt_q   <= '0;
			new_bytes_q <= '0;
		end else begin
			head_q      <= head_d;
			count_q     <= count_d;
			level_q     <= level_d;
			in_pkt_q    <= in_pkt_d;
			out_pkt_q   <= out_pkt_d;
			in_bytes_q  <= in_bytes_d;
			out_bytes_q <= out_bytes_d;
			new_pkt_q   <= new_pkt_d;
			new_bytes_q <= new_bytes_d;
		end
	end

	always_ff @(posedge clk) begin
		head_entry_q <= head_entry_d;
	end

endmodule

@@ design/packet_descriptor_fifo_with_stats.sv @@
// ----------------------------------------------------------------------------
// packet_descriptor_fifo_with_stats
// Bounded packet descriptor queue with head requeue and traffic counters.
// ----------------------------------------------------------------------------
// Takes one operation per cycle while the result side is not stalled and
// returns one result beat per operation. Each operation goes from the input
// register through the queue control into the result register; the
// descriptor store is read one entry ahead of the head and the head entry is
// held in a register, so a pop needs no wait on the store's registered read
// port. A stalled result beat holds the input register, and the input side
// stalls only while both are full. Up to DEPTH descriptors are held. The
// occupancy limit and the queue class are written through the configuration
// port, by the user only while the block is idle; not enforced by the block.
module packet_descriptor_fifo_with_stats #(
	parameter int unsigned DEPTH       = 64,
	parameter int unsigned HANDLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pdfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pdfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [pdfs_pkg::OP_W-1:0]          operation,
	input  logic                               item_kind,
	input  logic [pdfs_pkg::LEN_W-1:0]         total_length,
	input  logic [pdfs_pkg::LEN_W-1:0]         data_length,
	input  logic [pdfs_pkg::HANDLE_W-1:0]      handle,
	input  logic [pdfs_pkg::CLASS_W-1:0]       class_to_clear,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic                               accepted,
	output logic [pdfs_pkg::HANDLE_W-1:0]      out_handle,
	output logic [pdfs_pkg::QCOUNT_W-1:0]      queued_packets,
	output logic [pdfs_pkg::CNT_W-1:0]         queued_bytes,
	output logic [pdfs_pkg::CNT_W-1:0]         in_packets,
	output logic [pdfs_pkg::CNT_W-1:0]         out_packets,
	output logic [pdfs_pkg::CNT_W-1:0]         in_bytes,
	output logic [pdfs_pkg::CNT_W-1:0]         out_bytes,
	output logic [pdfs_pkg::CNT_W-1:0]         new_packets,
	output logic [pdfs_pkg::CNT_W-1:0]         new_bytes
);

	localparam int unsigned AW  = $clog2(DEPTH);
	localparam int unsigned SHB = (HANDLE_BITS < pdfs_pkg::HANDLE_W) ?
		HANDLE_BITS : pdfs_pkg::HANDLE_W;
	localparam int unsigned EW  = SHB + pdfs_pkg::LEN_W;

	logic [pdfs_pkg::QCOUNT_W-1:0] max_packets_q;
	logic [pdfs_pkg::CLASS_W-1:0]  queue_class_q;

	pdfs_pkg::item_t   item_s1;
	logic              valid_s1;
	pdfs_pkg::result_t result_s2;
	pdfs_pkg::result_t result_d;
	logic              valid_s2;
	logic              advance;
	logic              fire;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;

	assign advance    = !valid_s2 || result_ready;
	assign fire       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_packets_q <= pdfs_pkg::MAX_PACKETS_RST;
			queue_class_q <= pdfs_pkg::QUEUE_CLASS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdfs_pkg::REG_MAX_PACKETS: max_packets_q <= cfg_wdata;
				pdfs_pkg::REG_QUEUE_CLASS: queue_class_q <= cfg_wdata[pdfs_pkg::CLASS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1.operation      <= operation;
			item_s1.item_kind      <= item_kind;
			item_s1.total_length   <= total_length;
			item_s1.data_length    <= data_length;
			item_s1.handle         <= handle;
			item_s1.class_to_clear <= class_to_clear;
		end
		if (fire) begin
			result_s2 <= result_d;
		end
	end

	pdfs_queue_ctrl #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.max_packets (max_packets_q),
		.queue_class (queue_class_q),
		.ram_rdata   (ram_rdata),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.result      (result_d)
	);

	pdfs_entry_ram #(
		.DEPTH (DEPTH),
		.WIDTH (EW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr  (ram_raddr),
		.rdata  (ram_rdata)
	);

	assign result_valid   = valid_s2;
	assign accepted       = result_s2.accepted;
	assign out_handle     = result_s2.out_handle;
	assign queued_packets = result_s2.queued_packets;
	assign queued_bytes   = result_s2.queued_bytes;
	assign in_packets     = result_s2.in_packets;
	assign out_packets    = result_s2.out_packets;
	assign in_bytes       = result_s2.in_bytes;
	assign out_bytes      = result_s2.out_bytes;
	assign new_packets    = result_s2.new_packets;
	assign new_bytes      = result_s2.new_bytes;

endmodule

@@ design/pdfs_checker.sv @@
// ----------------------------------------------------------------------------
// pdfs_checker
// Port-level checks of the packet descriptor queue, bound to the top level.
// ----------------------------------------------------------------------------
module pdfs_checker #(
	parameter int unsigned DEPTH = 64
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_we,
	input logic [pdfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input logic [pdfs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic [pdfs_pkg::OP_W-1:0]          operation,
	input logic                               item_kind,
	input logic [pdfs_pkg::LEN_W-1:0]         total_length,
	input logic [pdfs_pkg::LEN_W-1:0]         data_length,
	input logic [pdfs_pkg::HANDLE_W-1:0]      handle,
	input logic [pdfs_pkg::CLASS_W-1:0]       class_to_clear,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic                               accepted,
	input logic [pdfs_pkg::HANDLE_W-1:0]      out_handle,
	input logic [pdfs_pkg::QCOUNT_W-1:0]      queued_packets,
	input logic [pdfs_pkg::CNT_W-1:0]         queued_bytes,
	input logic [pdfs_pkg::CNT_W-1:0]         in_packets,
	input logic [pdfs_pkg::CNT_W-1:0]         out_packets,
	input logic [pdfs_pkg::CNT_W-1:0]         in_bytes,
	input logic [pdfs_pkg::CNT_W-1:0]         out_bytes,
	input logic [pdfs_pkg::CNT_W-1:0]         new_packets,
	input logic [pdfs_pkg::CNT_W-1:0]         new_bytes
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(accepted)
			&& $stable(out_handle) && $stable(queued_packets) && $stable(queued_bytes))
		else $error("result beat changed while stalled");

	a_beat_origin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !$past(result_valid) |-> $past(item_valid && item_ready, 2))
		else $error("result beat without a taken item");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> int'(queued_packets) <= int'(DEPTH))
		else $error("occupancy above depth");

	a_empty_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && queued_packets == '0 |-> queued_bytes == '0)
		else $error("empty queue reports bytes");

	a_handle_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !accepted |-> out_handle == '0)
		else $error("handle reported without a pop");

endmodule

bind packet_descriptor_fifo_with_stats pdfs_checker #(.DEPTH(DEPTH)) u_pdfs_checker (.*);

@@ tb/pdfs_checker.sv @@
// ----------------------------------------------------------------------------
// pdfs_scoreboard
// Watches the operation and status channels of the descriptor queue, tracks
// the configuration writes, predicts every status beat from its own copy of
// the queue and counters, and compares each returned beat field by field.
// ----------------------------------------------------------------------------
module pdfs_scoreboard
	import pdfs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   item_valid,
	input  logic                   item_ready,
	input  item_t                  item,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  result_t                status,
	output int unsigned            fail_count,
	output int unsigned            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [QCOUNT_W-1:0] SLOTS = 7'd64;

	logic [HANDLE_W-1:0] slot_handle [64];
	logic [LEN_W-1:0]    slot_len [64];
	logic [5:0]          head;
	logic [QCOUNT_W-1:0] level_pkts;
	logic [CNT_W-1:0]    level_bytes;
	logic [CNT_W-1:0]    rx_pkts;
	logic [CNT_W-1:0]    tx_pkts;
	logic [CNT_W-1:0]    rx_bytes;
	logic [CNT_W-1:0]    tx_bytes;
	logic [CNT_W-1:0]    fresh_pkts;
	logic [CNT_W-1:0]    fresh_bytes;
	logic [QCOUNT_W-1:0] cap;
	logic [CLASS_W-1:0]  qclass;

	result_t     status_due [$];
	result_t     want;
	result_t     pred;
	int unsigned n_fail = 0;
	int unsigned n_due = 0;
	int unsigned n_beats = 0;

	assign fail_count  = n_fail;
	assign outstanding = n_due;

	task automatic report(input string msg);
		n_fail++;
		$display("[%0t] status beat %0d: %s", $time, n_beats, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report($sformatf("%s is %0h, expected %0h", name, got, exp_val));
	endtask

	function automatic result_t apply_descriptor_op(input item_t it);
		result_t          r;
		logic [LEN_W-1:0] len;
		logic [5:0]       slot;
		logic [QCOUNT_W-1:0] limit;
		r = '0;
		limit = (cap > SLOTS) ? SLOTS : cap;
		case (it.operation)
		OP_PUSH: begin
			if (level_pkts < limit) begin
				len = it.item_kind ? it.total_length : it.data_length;
				slot = head + level_pkts[5:0];
				slot_handle[slot] = it.handle;
				slot_len[slot] = len;
				level_pkts++;
				fresh_pkts++;
				fresh_bytes += len;
				level_bytes += len;
				rx_pkts++;
				rx_bytes += len;
				r.accepted = 1'b1;
			end
		end
		OP_PUSH_FRONT: begin
			if (level_pkts < limit) begin
				head = head - 1'b1;
				slot_handle[head] = it.handle;
				slot_len[head] = it.total_length;
				level_pkts++;
				level_bytes += it.total_length;
				tx_bytes -= it.total_length;
				r.accepted = 1'b1;
			end
		end
		OP_POP: begin
			if (level_pkts != 0) begin
				r.out_handle = slot_handle[head];
				len = slot_len[head];
				head++;
				level_pkts--;
				level_bytes -= len;
				tx_pkts++;
				tx_bytes += len;
				r.accepted = 1'b1;
			end
		end
		OP_READ_STATS: begin
			r.in_packets  = rx_pkts;
			r.out_packets = tx_pkts;
			r.in_bytes    = rx_bytes;
			r.out_bytes   = tx_bytes;
			rx_pkts  = '0;
			tx_pkts  = '0;
			rx_bytes = '0;
			tx_bytes = '0;
		end
		OP_CLEAR_NEW: begin
			if (it.class_to_clear == qclass)
				fresh_pkts = '0;
		end
		OP_FLUSH: begin
			head        = '0;
			level_pkts  = '0;
			level_bytes = '0;
			fresh_pkts  = '0;
			fresh_bytes = '0;
			rx_pkts     = '0;
			tx_pkts     = '0;
			rx_bytes    = '0;
			tx_bytes    = '0;
		end
		default: ;
		endcase
		if (it.operation != OP_READ_STATS) begin
			r.in_packets  = rx_pkts;
			r.out_packets = tx_pkts;
			r.in_bytes    = rx_bytes;
			r.out_bytes   = tx_bytes;
		end
		r.queued_packets = level_pkts;
		r.queued_bytes   = level_bytes;
		r.new_packets    = fresh_pkts;
		r.new_bytes      = fresh_bytes;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head        = '0;
			level_pkts  = '0;
			level_bytes = '0;
			rx_pkts     = '0;
			tx_pkts     = '0;
			rx_bytes    = '0;
			tx_bytes    = '0;
			fresh_pkts  = '0;
			fresh_bytes = '0;
			cap         = MAX_PACKETS_RST;
			qclass      = QUEUE_CLASS_RST;
			status_due.delete();
			n_due = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (status_due.size() == 0) begin
					report("beat with nothing pending");
				end else begin
					want = status_due.pop_front();
					check_field("accepted", 32'(status.accepted), 32'(want.accepted));
					check_field("out_handle", 32'(status.out_handle),
						32'(want.out_handle));
					check_field("queued_packets", 32'(status.queued_packets),
						32'(want.queued_packets));
					check_field("queued_bytes", status.queued_bytes, want.queued_bytes);
					check_field("in_packets", status.in_packets, want.in_packets);
					check_field("out_packets", status.out_packets, want.out_packets);
					check_field("in_bytes", status.in_bytes, want.in_bytes);
					check_field("out_bytes", status.out_bytes, want.out_bytes);
					check_field("new_packets", status.new_packets, want.new_packets);
					check_field("new_bytes", status.new_bytes, want.new_bytes);
				end
				n_beats++;
			end
			if (cfg_we) begin
				case (cfg_index)
				REG_MAX_PACKETS: cap = cfg_wdata;
				REG_QUEUE_CLASS: qclass = cfg_wdata[CLASS_W-1:0];
				default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				pred = apply_descriptor_op(item);
				status_due = {status_due, pred};
			end
			n_due = status_due.size();
		end
	end

endmodule

@@ tb/tb_packet_descriptor_fifo_with_stats.sv @@
// ----------------------------------------------------------------------------
// tb_packet_descriptor_fifo_with_stats
// Drives directed and random queue operations through the descriptor queue
// under several occupancy limits and queue classes, with bursty input and a
// stalling status consumer; the scoreboard beside the block predicts and
// compares every status beat.
// ----------------------------------------------------------------------------
module tb_packet_descriptor_fifo_with_stats;
	timeunit 1ns;
	timeprecision 1ps;

	import pdfs_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;
	localparam int unsigned     QUIET_LIMIT  = 1000;
	localparam int unsigned     PHASES       = 6;
	localparam int unsigned     FILL_BEATS   = 100;
	localparam int unsigned     DRAIN_BEATS  = 40;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   item_valid = 1'b0;
	logic                   item_ready;
	item_t                  beat = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                status;
	int unsigned            fail_count;
	int unsigned            outstanding;

	logic                   accepted;
	logic [HANDLE_W-1:0]    out_handle;
	logic [QCOUNT_W-1:0]    queued_packets;
	logic [CNT_W-1:0]       queued_bytes;
	logic [CNT_W-1:0]       in_packets;
	logic [CNT_W-1:0]       out_packets;
	logic [CNT_W-1:0]       in_bytes;
	logic [CNT_W-1:0]       out_bytes;
	logic [CNT_W-1:0]       new_packets;
	logic [CNT_W-1:0]       new_bytes;

	int unsigned            burst_left = 0;
	int unsigned            stall_left = 0;
	int unsigned            stall_mode = 0;
	int unsigned            quiet = 0;
	logic [CLASS_W-1:0]     class_now;
	logic [4:0]             pad;
	logic [QCOUNT_W-1:0]    cap_plan [PHASES] = '{7'd127, 7'd0, 7'd1, 7'd64, 7'd40, 7'd5};
	logic [CLASS_W-1:0]     class_plan [PHASES] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0};

	assign status = {accepted, out_handle, queued_packets, queued_bytes, in_packets,
		out_packets, in_bytes, out_bytes, new_packets, new_bytes};

	packet_descriptor_fifo_with_stats dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.operation      (beat.operation),
		.item_kind      (beat.item_kind),
		.total_length   (beat.total_length),
		.data_length    (beat.data_length),
		.handle         (beat.handle),
		.class_to_clear (beat.class_to_clear),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.accepted       (accepted),
		.out_handle     (out_handle),
		.queued_packets (queued_packets),
		.queued_bytes   (queued_bytes),
		.in_packets     (in_packets),
		.out_packets    (out_packets),
		.in_bytes       (in_bytes),
		.out_bytes      (out_bytes),
		.new_packets    (new_packets),
		.new_bytes      (new_bytes)
	);

	pdfs_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (beat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic item_t mk(input logic [OP_W-1:0] op, input logic kind,
			input logic [LEN_W-1:0] tot, input logic [LEN_W-1:0] dat,
			input logic [HANDLE_W-1:0] hnd, input logic [CLASS_W-1:0] cls);
		item_t b;
		b.operation      = op;
		b.item_kind      = kind;
		b.total_length   = tot;
		b.data_length    = dat;
		b.handle         = hnd;
		b.class_to_clear = cls;
		return b;
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return LEN_W'($urandom);
	endfunction

	function automatic item_t random_beat(input int unsigned push_pct,
			input int unsigned flush_pct);
		item_t       b;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			b.operation = OP_PUSH;
		else if (r < push_pct + 8)
			b.operation = OP_PUSH_FRONT;
		else if (r < 86)
			b.operation = OP_POP;
		else if (r < 90)
			b.operation = OP_READ_STATS;
		else if (r < 95)
			b.operation = OP_CLEAR_NEW;
		else if (r < 95 + flush_pct)
			b.operation = OP_FLUSH;
		else
			b.operation = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
		b.item_kind      = 1'($urandom_range(0, 1));
		b.total_length   = pick_length();
		b.data_length    = pick_length();
		b.handle         = HANDLE_W'($urandom);
		b.class_to_clear = $urandom_range(0, 1) ? class_now : CLASS_W'($urandom_range(0, 3));
		return b;
	endfunction

	// call at a falling edge; returns at the falling edge after the beat is taken
	task automatic send(input item_t b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		item_valid <= 1'b1;
		beat <= b;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 64);
		end
		stall_left--;
		case (stall_mode)
		0: result_ready <= 1'b1;
		1: result_ready <= 1'($urandom_range(0, 1));
		2: result_ready <= ($urandom_range(0, 3) == 0);
		default: result_ready <= (stall_left % 8 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		class_now = QUEUE_CLASS_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send(mk(OP_POP, 1'b0, '0, '0, '0, 2'd0));
		send(mk(OP_PUSH, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 2'd0));
		send(mk(OP_PUSH, 1'b0, 16'h0000, 16'hFFFF, 16'h0000, 2'd3));
		send(mk(OP_PUSH_FRONT, 1'b0, 16'h1234, 16'hFFFF, 16'hA5A5, 2'd1));
		send(mk(OP_PUSH_FRONT, 1'b1, 16'hFFFF, 16'h0000, 16'h5A5A, 2'd2));
		send(mk(OP_POP, 1'b1, '0, '0, '0, 2'd0));
		send(mk(OP_POP, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3));
		send(mk(OP_READ_STATS, 1'b0, '0, '0, '0, 2'd0));
		send(mk(OP_READ_STATS, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3));
		send(mk(OP_CLEAR_NEW, 1'b0, '0, '0, '0, 2'd0));
		send(mk(OP_CLEAR_NEW, 1'b0, '0, '0, '0, 2'd3));
		send(mk(OP_CLEAR_NEW, 1'b0, '0, '0, '0, 2'd2));
		send(mk(OP_UNUSED_LO, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3));
		send(mk(OP_UNUSED_HI, 1'b0, '0, '0, '0, 2'd0));
		send(mk(OP_POP, 1'b0, '0, '0, '0, 2'd0));
		send(mk(OP_POP, 1'b0, '0, '0, '0, 2'd0));
		send(mk(OP_POP, 1'b0, '0, '0, '0, 2'd0));
		send(mk(OP_PUSH, 1'b1, 16'h0000, 16'hFFFF, 16'h0001, 2'd1));
		send(mk(OP_PUSH, 1'b0, 16'hFFFF, 16'h8001, 16'h8000, 2'd2));
		send(mk(OP_PUSH_FRONT, 1'b1, 16'h7FFE, 16'h0000, 16'h7FFF, 2'd0));
		send(mk(OP_FLUSH, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3));
		send(mk(OP_POP, 1'b0, '0, '0, '0, 2'd0));
		send(mk(OP_READ_STATS, 1'b0, '0, '0, '0, 2'd0));

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_reg(REG_MAX_PACKETS, cap_plan[p]);
			pad = 5'($urandom);
			write_reg(REG_QUEUE_CLASS, {pad, class_plan[p]});
			class_now = class_plan[p];
			repeat (FILL_BEATS) send(random_beat(70, 0));
			repeat (DRAIN_BEATS) send(random_beat(20, 2));
		end

		settle();
		repeat (6) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
